/* rtl/sdtq_pkg.sv */
// Package for the sorted delay timer queue: request/result types, command and
// reply codes, queue sizing. No dependencies.
`default_nettype none

package sdtq_pkg;

    localparam int QUEUE_SLOTS = 32;
    localparam int CNT_W       = $clog2(QUEUE_SLOTS + 1);
    localparam int TICK_W      = 31;
    localparam int TASK_W      = 8;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_TIME  = 2'd1;
    localparam logic [1:0] CMD_DELAY = 2'd2;
    localparam logic [1:0] CMD_UNTIL = 2'd3;

    localparam logic [1:0] KIND_TIME    = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_NEG     = 2'd2;
    localparam logic [1:0] KIND_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [TASK_W-1:0]  task_id;
        logic signed [31:0] tick_argument;
    } t_req;

    typedef struct packed {
        logic [TASK_W-1:0] reply_task;
        logic [1:0]        reply_kind;
        logic [TICK_W-1:0] reply_ticks;
        logic              last_reply;
    } t_rsp;

    typedef struct packed {
        logic [TICK_W-1:0] deadline;
        logic [TASK_W-1:0] task_id;
    } t_entry;

    // broadcast to every cell of the queue
    typedef struct packed {
        logic   insert;
        logic   shift;
        t_entry entry;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/sdtq_cell.sv */
// One slot of the sorted queue: holds an entry, shifts right on insert,
// left on head removal. Depends on sdtq_pkg.
`default_nettype none

module sdtq_cell (
    input  wire logic              i_clk,
    input  sdtq_pkg::t_cell_ctl    i_ctl,
    input  wire logic              i_occ,
    input  wire logic              i_prev_keep,
    input  sdtq_pkg::t_entry       i_prev,
    input  sdtq_pkg::t_entry       i_next,
    output sdtq_pkg::t_entry       o_entry,
    output logic                   o_keep
);

    sdtq_pkg::t_entry r_entry;

    // occupied and not later than the new deadline: stays put (keeps arrival order)
    assign o_keep  = i_occ && (r_entry.deadline <= i_ctl.entry.deadline);
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            if (!o_keep) begin
                r_entry <= i_prev_keep ? i_ctl.entry : i_prev;
            end
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/sorted_delay_timer_queue.sv */
// Top level of the sorted delay timer queue: command sequencer, tick counter
// and a row of sdtq_cell slots. Depends on sdtq_pkg and sdtq_cell.
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+---------------------------------------
//  request  | i_req (t_req)              | taken on edge with start=1, busy=0
//  result   | o_rsp (t_rsp)              | o_strobe for one cycle, no back-pressure
//
// Steps: a tick or a time query is accepted and then enters the drain loop,
// which shows the time reply first and then any releases; a tick with nothing
// due gives no reply. An error reply goes the same way. A queued delay is
// accepted, which latches the request and forms the deadline (31-bit add,
// saturate; an until request takes its argument as the deadline), then does
// the parallel sorted insert across the cells, then enters the drain loop,
// which releases one head entry per cycle by shifting the row left.
// Reset (i_rst_n low, synchronous) empties the queue and zeroes the tick count.
// The receiver cannot stall; each result shows for exactly one cycle.
`default_nettype none

module sorted_delay_timer_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  sdtq_pkg::t_req      i_req,
    output logic                o_strobe,
    output sdtq_pkg::t_rsp      o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_DRAIN
    } t_state;

    t_state                          r_state;
    logic [sdtq_pkg::TICK_W-1:0]     r_tick;
    logic [sdtq_pkg::CNT_W-1:0]      r_count;
    sdtq_pkg::t_entry                r_new;        // entry waiting for insert
    logic                            r_pend_v;     // direct reply waiting to go out
    sdtq_pkg::t_rsp                  r_pend;
    logic                            r_strobe;
    sdtq_pkg::t_rsp                  r_rsp;

    sdtq_pkg::t_cell_ctl             w_ctl;
    sdtq_pkg::t_entry                w_entry [sdtq_pkg::QUEUE_SLOTS];
    logic                            w_keep  [sdtq_pkg::QUEUE_SLOTS];

    logic                            w_accept;
    logic                            w_neg;
    logic                            w_full;
    logic [sdtq_pkg::TICK_W:0]       w_sum;
    logic [sdtq_pkg::TICK_W-1:0]     w_deadline;
    logic                            w_due0;
    logic                            w_due1;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // request decode
    assign w_neg  = i_req.tick_argument[31];
    assign w_full = (r_count == sdtq_pkg::CNT_W'(sdtq_pkg::QUEUE_SLOTS));
    assign w_sum  = {1'b0, r_tick} + {1'b0, i_req.tick_argument[sdtq_pkg::TICK_W-1:0]};

    always_comb begin
        if (i_req.command == sdtq_pkg::CMD_UNTIL) begin
            w_deadline = i_req.tick_argument[sdtq_pkg::TICK_W-1:0];
        end else if (w_sum[sdtq_pkg::TICK_W]) begin
            w_deadline = '1;        // saturate on overflow
        end else begin
            w_deadline = w_sum[sdtq_pkg::TICK_W-1:0];
        end
    end

    // head and next-to-head due checks
    assign w_due0 = (r_count != '0) && (w_entry[0].deadline <= r_tick);
    assign w_due1 = (r_count > sdtq_pkg::CNT_W'(1)) && (w_entry[1].deadline <= r_tick);

    assign w_ctl.insert = (r_state == S_INSERT);
    assign w_ctl.shift  = (r_state == S_DRAIN) && !r_pend_v && w_due0;
    assign w_ctl.entry  = r_new;

    // row of cells; cell 0 is the head
    for (genvar g = 0; g < sdtq_pkg::QUEUE_SLOTS; g++) begin : g_cell
        logic             w_prev_keep;
        sdtq_pkg::t_entry w_prev;
        sdtq_pkg::t_entry w_next;

        if (g == 0) begin : g_first
            assign w_prev_keep = 1'b1;
            assign w_prev      = r_new;
        end else begin : g_mid
            assign w_prev_keep = w_keep[g-1];
            assign w_prev      = w_entry[g-1];
        end

        if (g == sdtq_pkg::QUEUE_SLOTS - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_inner
            assign w_next = w_entry[g+1];
        end

        sdtq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (r_count > sdtq_pkg::CNT_W'(g)),
            .i_prev_keep (w_prev_keep),
            .i_prev      (w_prev),
            .i_next      (w_next),
            .o_entry     (w_entry[g]),
            .o_keep      (w_keep[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tick   <= '0;
            r_count  <= '0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state            <= S_DRAIN;
                        r_pend.reply_task  <= i_req.task_id;
                        // count for a time reply, zero for an error reply
                        r_pend.reply_ticks <= (i_req.command == sdtq_pkg::CMD_TIME) ?
                                              r_tick : '0;
                        // a direct reply closes the request unless releases follow
                        r_pend.last_reply  <= 1'b1;
                        r_new.deadline     <= w_deadline;
                        r_new.task_id      <= i_req.task_id;
                        unique case (i_req.command)
                            sdtq_pkg::CMD_TICK: begin
                                if (r_tick != '1) begin
                                    r_tick <= r_tick + 1'b1;
                                end
                            end
                            sdtq_pkg::CMD_TIME: begin
                                r_pend_v           <= 1'b1;
                                r_pend.reply_kind  <= sdtq_pkg::KIND_TIME;
                            end
                            sdtq_pkg::CMD_DELAY, sdtq_pkg::CMD_UNTIL: begin
                                if (w_neg) begin
                                    r_pend_v          <= 1'b1;
                                    r_pend.reply_kind <= sdtq_pkg::KIND_NEG;
                                end else if (w_full) begin
                                    r_pend_v          <= 1'b1;
                                    r_pend.reply_kind <= sdtq_pkg::KIND_FULL;
                                end else begin
                                    r_state <= S_INSERT;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_INSERT: begin
                    r_count <= r_count + 1'b1;
                    r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (r_pend_v) begin
                        // direct reply goes first, releases follow
                        r_pend_v          <= 1'b0;
                        r_strobe          <= 1'b1;
                        r_rsp.reply_task  <= r_pend.reply_task;
                        r_rsp.reply_kind  <= r_pend.reply_kind;
                        r_rsp.reply_ticks <= r_pend.reply_ticks;
                        r_rsp.last_reply  <= r_pend.last_reply && !w_due0;
                        if (!w_due0) begin
                            r_state <= S_IDLE;
                        end
                    end else if (w_due0) begin
                        r_strobe           <= 1'b1;
                        r_rsp.reply_task   <= w_entry[0].task_id;
                        r_rsp.reply_kind   <= sdtq_pkg::KIND_RELEASE;
                        r_rsp.reply_ticks  <= r_tick;
                        r_rsp.last_reply   <= !w_due1;
                        r_count            <= r_count - 1'b1;
                        if (!w_due1) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_IDLE;   // nothing due
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
